// ===== design/dsu_pkg.sv =====
// Shared types and constants for the disjoint-set union engine.
`default_nettype none
package dsu_pkg;

	localparam int NODES   = 1024;
	localparam int IDX_W   = $clog2(NODES);
	localparam int SIZE_W  = IDX_W + 1;
	localparam int ENTRY_W = SIZE_W + 1;

	localparam logic CMD_JOIN  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             command;
		logic [IDX_W-1:0] first_node;
		logic [IDX_W-1:0] second_node;
	} dsu_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  first_root;
		logic [IDX_W-1:0]  second_root;
		logic              already_joined;
		logic [IDX_W-1:0]  result_root;
		logic [SIZE_W-1:0] group_size;
	} dsu_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COMP,
		ST_MERGE,
		ST_GROW,
		ST_RESP
	} dsu_state_t;

endpackage
`default_nettype wire

// ===== design/dsu_mem.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module dsu_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 12,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/disjoint_set_union_engine.sv =====
// Disjoint-set union engine: union by size with path compression over one RAM.
//
// Request channel (cmd_valid/cmd_ready/cmd): a join of two elements or a query
// of one. Result channel (res_valid/res_ready/res): exactly one result per
// request, in request order.
// Each RAM entry holds a root flag plus either a parent link or a set size.
// Steps per request: an accept step; per walked element a walk of reads from the
// element up to its root, then, when the element is not its own root, a rewalk
// pointing each node on the path at the root; a join walks the second element
// too, then a merge step plus, when the roots differ, a size write; a response step ends it.
// Union by size keeps depths near log2(NODES). Only one request is worked at a
// time; the single RAM read port sets the walk pace.
// After reset a clearing pass writes every one of the NODES (1024) entries as a
// root of size one; cmd_ready stays low meanwhile.
// Results sit in an output register: when the receiver stalls, the engine
// still accepts and works the next request, then waits to hand its result on.
`default_nettype none
module disjoint_set_union_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire dsu_pkg::dsu_req_t cmd,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output dsu_pkg::dsu_rsp_t      res
);
	import dsu_pkg::*;

	// control state
	dsu_state_t        state_q, state_d;
	logic [IDX_W-1:0]  clr_q, clr_d;
	logic              phase_q, phase_d;     // 0: first element, 1: second
	logic              query_q, query_d;
	logic [IDX_W-1:0]  second_q, second_d;
	logic [IDX_W-1:0]  cur_q, cur_d;         // node whose read is in flight
	logic [IDX_W-1:0]  start_q, start_d;     // head of the path being walked
	logic [IDX_W-1:0]  root_a_q, root_a_d;
	logic [IDX_W-1:0]  root_b_q, root_b_d;
	logic [SIZE_W-1:0] size_a_q, size_a_d;
	logic [SIZE_W-1:0] size_b_q, size_b_d;
	logic              res_valid_q;
	dsu_rsp_t          res_q;

	// RAM port
	logic               mem_we, mem_re;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

	logic              rd_is_root;
	logic [SIZE_W-1:0] rd_val;
	logic [IDX_W-1:0]  rd_link;
	logic [IDX_W-1:0]  walk_root;
	logic              walk_done;
	logic              same_root, a_small;
	logic [SIZE_W-1:0] total;
	logic [IDX_W-1:0]  winner, loser;
	logic              load_res;
	dsu_rsp_t          rsp_d;

	dsu_mem #(
		.DEPTH(NODES),
		.WIDTH(ENTRY_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_is_root = mem_rdata[ENTRY_W-1];
	assign rd_val     = mem_rdata[SIZE_W-1:0];
	assign rd_link    = rd_val[IDX_W-1:0];
	assign walk_root  = phase_q ? root_b_q : root_a_q;

	assign same_root = (root_a_q == root_b_q);
	assign a_small   = (size_a_q < size_b_q);
	assign total     = size_a_q + size_b_q;
	assign winner    = a_small ? root_b_q : root_a_q;
	assign loser     = a_small ? root_a_q : root_b_q;

	// result fields, valid in ST_RESP
	always_comb begin
		rsp_d.first_root = root_a_q;
		if (query_q || same_root) begin
			rsp_d.second_root    = query_q ? root_a_q : root_b_q;
			rsp_d.already_joined = 1'b1;
			rsp_d.result_root    = root_a_q;
			rsp_d.group_size     = size_a_q;
		end else begin
			rsp_d.second_root    = root_b_q;
			rsp_d.already_joined = 1'b0;
			rsp_d.result_root    = winner;
			rsp_d.group_size     = total;
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign load_res  = (state_q == ST_RESP) && (!res_valid_q || res_ready);

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		phase_d   = phase_q;
		query_d   = query_q;
		second_d  = second_q;
		cur_d     = cur_q;
		start_d   = start_q;
		root_a_d  = root_a_q;
		root_b_d  = root_b_q;
		size_a_d  = size_a_q;
		size_b_d  = size_b_q;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = {1'b0, SIZE_W'(walk_root)};
		mem_re    = 1'b0;
		mem_raddr = rd_link;
		walk_done = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {1'b1, SIZE_W'(1)};
				clr_d     = clr_q + IDX_W'(1);
				if (clr_q == IDX_W'(NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					mem_re    = 1'b1;
					mem_raddr = cmd.first_node;
					cur_d     = cmd.first_node;
					start_d   = cmd.first_node;
					second_d  = cmd.second_node;
					query_d   = (cmd.command == CMD_QUERY);
					phase_d   = 1'b0;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				if (rd_is_root) begin
					if (phase_q) begin
						root_b_d = cur_q;
						size_b_d = rd_val;
					end else begin
						root_a_d = cur_q;
						size_a_d = rd_val;
					end
					if (cur_q == start_q) begin
						walk_done = 1'b1;
					end else begin
						// rewalk the path from its head
						mem_re    = 1'b1;
						mem_raddr = start_q;
						cur_d     = start_q;
						state_d   = ST_COMP;
					end
				end else begin
					mem_re = 1'b1;
					cur_d  = rd_link;
				end
			end
			ST_COMP: begin
				if (rd_is_root) begin
					walk_done = 1'b1;
				end else begin
					mem_we = 1'b1;
					mem_re = 1'b1;
					cur_d  = rd_link;
				end
			end
			ST_MERGE: begin
				if (same_root) begin
					state_d = ST_RESP;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = loser;
					mem_wdata = {1'b0, SIZE_W'(winner)};
					state_d   = ST_GROW;
				end
			end
			ST_GROW: begin
				mem_we    = 1'b1;
				mem_waddr = winner;
				mem_wdata = {1'b1, total};
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (load_res) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (walk_done) begin
			if (phase_q) begin
				state_d = ST_MERGE;
			end else if (query_q) begin
				state_d = ST_RESP;
			end else begin
				mem_re    = 1'b1;
				mem_raddr = second_q;
				cur_d     = second_q;
				start_d   = second_q;
				phase_d   = 1'b1;
				state_d   = ST_WALK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			phase_q     <= 1'b0;
			query_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			phase_q <= phase_d;
			query_q <= query_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		second_q <= second_d;
		cur_q    <= cur_d;
		start_q  <= start_d;
		root_a_q <= root_a_d;
		root_b_q <= root_b_d;
		size_a_q <= size_a_d;
		size_b_q <= size_b_d;
		if (load_res) begin
			res_q <= rsp_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// a compression write never lands on the entry being read
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("RAM write and read hit the same entry");

	// the clearing pass runs once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("clearing pass restarted");

	// a stalled result holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("result changed while stalled");

	// a result never reports an empty set
	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.group_size != '0))
		else $error("zero set size reported");
`endif

endmodule
`default_nettype wire
